// File: rtl/mbe_pkg.sv
// mbe_pkg: fixed-point constants, register indexes and sequencer states
// for the mandelbrot escape-time core; no dependencies
package mbe_pkg;

  // signed fixed point, 28 fraction bits
  localparam int FRAC_BITS = 28;

  // coordinate clamp limits for pixel indexes
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = 12;
  localparam int ITER_W = 17;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // width of a truncated product and of the z registers
  localparam int PSH_W = 36;
  localparam int Z_W   = 34;

  // quick test and escape thresholds
  localparam logic signed [PSH_W:0]   QUICK_LIM = (PSH_W+1)'(64'sd1 <<< (FRAC_BITS - 4));
  localparam logic signed [PSH_W:0]   FOUR      = (PSH_W+1)'(64'sd4 <<< FRAC_BITS);
  localparam logic signed [PSH_W-1:0] TWO       = PSH_W'(64'sd2 <<< FRAC_BITS);

  // saturation bounds for the coordinates
  localparam logic signed [44:0] SAT_MAX = 45'sh0_7FFF_FFFF;
  localparam logic signed [44:0] SAT_MIN = -45'sh0_8000_0000;

  // register reset values
  localparam logic [DATA_W-1:0] RST_LEFT  = 32'hE000_0000;
  localparam logic [DATA_W-1:0] RST_STEP  = 32'h0004_0000;
  localparam logic [ITER_W-1:0] RST_LIMIT = 17'd100000;

  // register indexes
  typedef enum logic [2:0] {
    REG_REAL_LEFT  = 3'd0,
    REG_REAL_STEP  = 3'd1,
    REG_IMAG_LOWER = 3'd2,
    REG_IMAG_STEP  = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } reg_idx_t;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_MUL_RE = 12'b0000_0000_0010,
    ST_MUL_IM = 12'b0000_0000_0100,
    ST_SQ_CR  = 12'b0000_0000_1000,
    ST_SQ_CI  = 12'b0000_0001_0000,
    ST_QUICK  = 12'b0000_0010_0000,
    ST_MUL_RI = 12'b0000_0100_0000,
    ST_UPDATE = 12'b0000_1000_0000,
    ST_SQ_ZR  = 12'b0001_0000_0000,
    ST_SQ_ZI  = 12'b0010_0000_0000,
    ST_CHECK  = 12'b0100_0000_0000,
    ST_DONE   = 12'b1000_0000_0000
  } state_t;

endpackage

// File: rtl/mandelbrot_escape_iteration_core.sv
// mandelbrot_escape_iteration_core: escape-time counter for one pixel at a time
// on a single shared 32x32 signed multiplier; depends on mbe_pkg
//
// usage:
//   the input channel (in_valid/in_stall) takes one item, a pixel column and row.
//   the result channel (out_valid/out_stall) returns one item per input: the
//   escape count and a copy of column and row. results keep input order.
//   the register port (psel/penable/pwrite, paddr, pwdata, prdata, pready) holds
//   real_left, real_step, imag_lower, imag_step and iteration_limit at byte
//   addresses 0, 4, 8, 12, 16; write it only while the core is idle.
// sequencing:
//   every product goes through the one registered multiplier. mapping the pixel
//   and the quick test take the states MUL_RE, MUL_IM, SQ_CR, SQ_CI and QUICK;
//   each z = z^2 + c iteration takes MUL_RI, UPDATE, SQ_ZR, SQ_ZI and CHECK.
//   DONE loads the result register, and only then does the core return to idle
//   and take the next item, so one pixel is finished before the next is taken.
//   in_stall is high from acceptance until the result moves to the output
//   register; the next item can be taken while that result still waits.
// reset:
//   synchronous active-low rst_n clears the sequencer and the output valid and
//   loads the register reset values (view -2-2i with step 2^-10, limit 100000).
// stall:
//   while out_stall holds a result, a finished count waits in the sequencer.
module mandelbrot_escape_iteration_core
  import mbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COL_W-1:0]    in_column,
  input  logic [COL_W-1:0]    in_row,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ITER_W-1:0]   out_iterations,
  output logic [COL_W-1:0]    out_pixel_column,
  output logic [COL_W-1:0]    out_pixel_row,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // configuration registers
  logic signed [DATA_W-1:0] left_r, rstep_r, lower_r, istep_r;
  logic [ITER_W-1:0]        limit_r;

  // sequencer and datapath registers
  state_t                   state_r, state_nxt;
  logic [COL_W-1:0]         col_r, col_nxt, row_r, row_nxt;
  logic signed [DATA_W-1:0] cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [PSH_W-1:0]  rr_r, rr_nxt, ii_r, ii_nxt;
  logic signed [Z_W-1:0]    zr_r, zr_nxt, zi_r, zi_nxt;
  logic [ITER_W-1:0]        n_r, n_nxt;
  logic signed [63:0]       prod_r;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [ITER_W-1:0]        out_iter_r, out_iter_nxt;
  logic [COL_W-1:0]         out_col_r, out_col_nxt, out_row_r, out_row_nxt;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic [COL_W-1:0]         idx_c, idx_r;
  logic signed [PSH_W-1:0]  prod_sh;
  logic signed [44:0]       coord_sum;
  logic signed [DATA_W-1:0] coord_base, coord_sat;
  logic signed [PSH_W:0]    mag_sum;
  logic signed [PSH_W-1:0]  zr_calc, zi_calc;
  logic                     out_free, z_out;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign in_stall = (state_r != ST_IDLE);

  assign out_valid        = out_valid_r;
  assign out_iterations   = out_iter_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_row    = out_row_r;
  assign out_free         = !out_valid_r || !out_stall;

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_REAL_LEFT:  prdata = left_r;
      REG_REAL_STEP:  prdata = rstep_r;
      REG_IMAG_LOWER: prdata = lower_r;
      REG_IMAG_STEP:  prdata = istep_r;
      REG_ITER_LIMIT: prdata = {{(DATA_W-ITER_W){1'b0}}, limit_r};
      default:        prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= RST_LEFT;
      rstep_r <= RST_STEP;
      lower_r <= RST_LEFT;
      istep_r <= RST_STEP;
      limit_r <= RST_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_REAL_LEFT:  left_r  <= pwdata;
        REG_REAL_STEP:  rstep_r <= pwdata;
        REG_IMAG_LOWER: lower_r <= pwdata;
        REG_IMAG_STEP:  istep_r <= pwdata;
        REG_ITER_LIMIT: limit_r <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // index clamp for the coordinate mapping
  assign idx_c = (17'(col_r) >= 17'(MAX_WIDTH))  ? COL_W'(MAX_WIDTH - 1)  : col_r;
  assign idx_r = (17'(row_r) >= 17'(MAX_HEIGHT)) ? COL_W'(MAX_HEIGHT - 1) : row_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_RE: begin
        mul_a = {{(DATA_W-COL_W){1'b0}}, idx_c};
        mul_b = rstep_r;
      end
      ST_MUL_IM: begin
        mul_a = {{(DATA_W-COL_W){1'b0}}, idx_r};
        mul_b = istep_r;
      end
      ST_SQ_CR: begin
        mul_a = cr_r;
        mul_b = cr_r;
      end
      ST_SQ_CI: begin
        mul_a = ci_r;
        mul_b = ci_r;
      end
      ST_MUL_RI: begin
        mul_a = zr_r[DATA_W-1:0];
        mul_b = zi_r[DATA_W-1:0];
      end
      ST_SQ_ZR: begin
        mul_a = zr_r[DATA_W-1:0];
        mul_b = zr_r[DATA_W-1:0];
      end
      ST_SQ_ZI: begin
        mul_a = zi_r[DATA_W-1:0];
        mul_b = zi_r[DATA_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // product floored back to the fraction position
  assign prod_sh = prod_r[FRAC_BITS+PSH_W-1:FRAC_BITS];

  // base plus index times step, saturated to 32 bits
  assign coord_base = (state_r == ST_MUL_IM) ? left_r : lower_r;
  assign coord_sum  = {{13{coord_base[DATA_W-1]}}, coord_base} + prod_r[44:0];
  always_comb begin
    if (coord_sum > SAT_MAX) begin
      coord_sat = SAT_MAX[DATA_W-1:0];
    end else if (coord_sum < SAT_MIN) begin
      coord_sat = SAT_MIN[DATA_W-1:0];
    end else begin
      coord_sat = coord_sum[DATA_W-1:0];
    end
  end

  // squared magnitude from the stored real square and the fresh product
  assign mag_sum = {rr_r[PSH_W-1], rr_r} + {prod_sh[PSH_W-1], prod_sh};

  // one z = z^2 + c update
  assign zr_calc = rr_r - ii_r + {{(PSH_W-DATA_W){cr_r[DATA_W-1]}}, cr_r};
  assign zi_calc = (prod_sh <<< 1) + {{(PSH_W-DATA_W){ci_r[DATA_W-1]}}, ci_r};
  assign z_out   = (zr_calc > TWO) || (zr_calc < -TWO) ||
                   (zi_calc > TWO) || (zi_calc < -TWO);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_iter_nxt  = out_iter_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          col_nxt   = in_column;
          row_nxt   = in_row;
          state_nxt = ST_MUL_RE;
        end
      end
      ST_MUL_RE: state_nxt = ST_MUL_IM;
      ST_MUL_IM: begin
        cr_nxt    = coord_sat;
        state_nxt = ST_SQ_CR;
      end
      ST_SQ_CR: begin
        ci_nxt    = coord_sat;
        state_nxt = ST_SQ_CI;
      end
      ST_SQ_CI: begin
        rr_nxt    = prod_sh;
        state_nxt = ST_QUICK;
      end
      ST_QUICK: begin
        // points near the origin are inside at once
        rr_nxt = '0;
        ii_nxt = '0;
        zr_nxt = '0;
        zi_nxt = '0;
        if (mag_sum < QUICK_LIM) begin
          n_nxt     = limit_r;
          state_nxt = ST_DONE;
        end else begin
          n_nxt     = '0;
          state_nxt = (limit_r == '0) ? ST_DONE : ST_MUL_RI;
        end
      end
      ST_MUL_RI: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        zr_nxt    = zr_calc[Z_W-1:0];
        zi_nxt    = zi_calc[Z_W-1:0];
        n_nxt     = n_r + 1'b1;
        state_nxt = z_out ? ST_DONE : ST_SQ_ZR;
      end
      ST_SQ_ZR: state_nxt = ST_SQ_ZI;
      ST_SQ_ZI: begin
        rr_nxt    = prod_sh;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // the squares double as the next iteration's terms
        ii_nxt = prod_sh;
        if (mag_sum > FOUR || n_r >= limit_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL_RI;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_iter_nxt  = n_r;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    rr_r       <= rr_nxt;
    ii_r       <= ii_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    n_r        <= n_nxt;
    out_iter_r <= out_iter_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
  end

  // a new result only comes from the done state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside done state");

  // a count never passes the limit
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_iter_r <= limit_r))
    else $error("iteration count above limit");

  // z fed to the multiplier stays inside the escape radius
  a_z_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_RI) |->
      (zr_r <= TWO && zr_r >= -TWO && zi_r <= TWO && zi_r >= -TWO))
    else $error("escaped z reached the multiplier");

  // a pending result is held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_iter_r)))
    else $error("stalled result lost");

endmodule
